// File: design/ismix_pkg.sv
// ----------------------------------------------------------------------------
// ismix_pkg: shared constants and types of the insert send/return mixer
// Register indexes, fixed field widths, arithmetic step codes and the
// control groups that pass between the top level and the multiply unit.
// ----------------------------------------------------------------------------
package ismix_pkg;

   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int GAIN_BITS     = 16;
   localparam int MIX_BITS      = 17;
   localparam int LATENCY_BITS  = 12;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam int GAIN_FRAC = 14;   // Q2.14 gains
   localparam int MIX_FRAC  = 16;   // Q1.16 wet mix

   localparam logic [MIX_BITS-1:0]  MIX_FULL          = MIX_BITS'(65536);
   localparam logic [GAIN_BITS-1:0] SEND_GAIN_RESET   = GAIN_BITS'(16384);
   localparam logic [GAIN_BITS-1:0] RETURN_GAIN_RESET = GAIN_BITS'(16384);
   localparam logic [MIX_BITS-1:0]  WET_MIX_RESET     = MIX_BITS'(32768);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEND_GAIN   = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETURN_GAIN = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET_MIX     = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_LATENCY     = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BYPASS      = CSR_IDX_BITS'(4);
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEREO      = CSR_IDX_BITS'(5);

   // multiply sequence; the product of step n is consumed in step n+1
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_SEND_L = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_SEND_R = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_WET_L  = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_WET_R  = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_DRY_L  = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] STEP_MIX_L  = STEP_BITS'(5);
   localparam logic [STEP_BITS-1:0] STEP_DRY_R  = STEP_BITS'(6);
   localparam logic [STEP_BITS-1:0] STEP_MIX_R  = STEP_BITS'(7);
   localparam logic [STEP_BITS-1:0] STEP_LAST   = STEP_BITS'(8);

   typedef struct packed {
      logic [GAIN_BITS-1:0] send_gain;
      logic [GAIN_BITS-1:0] return_gain;
      logic [MIX_BITS-1:0]  wet_mix;      // already clamped to MIX_FULL
   } gain_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_stat_type;

endpackage

// File: design/ismix_ram.sv
// ----------------------------------------------------------------------------
// ismix_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ismix_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ismix_delay.sv
// ----------------------------------------------------------------------------
// ismix_delay: latency compensation delay line
// Two circular memories for the return pair, write pointer, read address
// from the clamped latency. Entries never written read as zero (wrap flag);
// zero latency forwards the word being written.
// ----------------------------------------------------------------------------
module ismix_delay import ismix_pkg::*; #(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_strobe,
   input  logic                          rd_strobe,
   input  logic signed [SAMPLE_BITS-1:0] ret_l,
   input  logic signed [SAMPLE_BITS-1:0] ret_r,
   input  logic [LATENCY_BITS-1:0]       latency,
   output logic signed [SAMPLE_BITS-1:0] wet_l,
   output logic signed [SAMPLE_BITS-1:0] wet_r
);

   localparam int PW = $clog2(DELAY_DEPTH);
   localparam int CW = (PW > LATENCY_BITS) ? PW : LATENCY_BITS;

   logic [PW-1:0] wp_ff, wp_in, rd_addr, lat_p;
   logic [CW-1:0] lat_x, lat_c;
   logic          wp_last, wrapped_ff;
   logic          fwd_ff, hit_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_l_ff, fwd_r_ff;
   logic [SAMPLE_BITS-1:0]        q_l, q_r;

   assign lat_x   = CW'(latency);
   assign lat_c   = (lat_x > CW'(DELAY_DEPTH - 1)) ? CW'(DELAY_DEPTH - 1) : lat_x;
   assign lat_p   = PW'(lat_c);
   assign wp_last = (wp_ff == PW'(DELAY_DEPTH - 1));
   assign wp_in   = wp_last ? '0 : wp_ff + 1'b1;

   always_comb begin
      if (wp_ff >= lat_p) begin
         rd_addr = wp_ff - lat_p;
      end else begin
         rd_addr = PW'((PW+1)'(wp_ff) + (PW+1)'(DELAY_DEPTH) - (PW+1)'(lat_p));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (wr_strobe) begin
         wp_ff <= wp_in;
         if (wp_last) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   // read side flags, aligned with the registered RAM output
   always_ff @(posedge clock) begin
      if (rd_strobe) begin
         fwd_ff   <= (lat_p == '0);
         hit_ff   <= wrapped_ff || (wp_ff >= lat_p);
         fwd_l_ff <= ret_l;
         fwd_r_ff <= ret_r;
      end
   end

   ismix_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_l (
      .clock   (clock),
      .wr_en   (wr_strobe),
      .wr_addr (wp_ff),
      .wr_data (ret_l),
      .rd_en   (rd_strobe),
      .rd_addr (rd_addr),
      .rd_data (q_l)
   );

   ismix_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_r (
      .clock   (clock),
      .wr_en   (wr_strobe),
      .wr_addr (wp_ff),
      .wr_data (ret_r),
      .rd_en   (rd_strobe),
      .rd_addr (rd_addr),
      .rd_data (q_r)
   );

   assign wet_l = fwd_ff ? fwd_l_ff : (hit_ff ? $signed(q_l) : '0);
   assign wet_r = fwd_ff ? fwd_r_ff : (hit_ff ? $signed(q_r) : '0);

endmodule

// File: design/ismix_mac.sv
// ----------------------------------------------------------------------------
// ismix_mac: shared multiplier with step sequencer
// One signed multiply per cycle, product registered; the next step rounds,
// saturates or accumulates it. Eight products per frame.
// ----------------------------------------------------------------------------
module ismix_mac import ismix_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  gain_cfg_type                  cfg,
   input  logic signed [SAMPLE_BITS-1:0] dry_l,
   input  logic signed [SAMPLE_BITS-1:0] dry_r,
   input  logic signed [SAMPLE_BITS-1:0] wet_l,
   input  logic signed [SAMPLE_BITS-1:0] wet_r,
   output mac_stat_type                  stat,
   output logic signed [SAMPLE_BITS-1:0] send_l,
   output logic signed [SAMPLE_BITS-1:0] send_r,
   output logic signed [SAMPLE_BITS-1:0] out_l,
   output logic signed [SAMPLE_BITS-1:0] out_r
);

   localparam int WW  = SAMPLE_BITS + 2;        // scaled wet sample
   localparam int PRW = WW + MIX_BITS + 1;      // product
   localparam int SW  = PRW + 1;                // sum / rounding width

   localparam logic signed [SW-1:0] HALF_GAIN = SW'(1) <<< (GAIN_FRAC - 1);
   localparam logic signed [SW-1:0] HALF_MIX  = SW'(1) <<< (MIX_FRAC - 1);
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO =
      {{(SW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SW-1:0] v
   );
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   logic [STEP_BITS-1:0]    step_ff;
   logic                    busy_ff;
   logic signed [WW-1:0]    mul_a;
   logic signed [MIX_BITS:0] mul_b;
   logic signed [PRW-1:0]   prod_ff, prod_in, acc_ff;
   logic signed [WW-1:0]    wl_ff, wr_ff;
   logic [MIX_BITS-1:0]     dry_w;
   logic signed [SW-1:0]    prod_x, gain_rnd, blend_sum, blend_rnd;
   logic signed [SAMPLE_BITS-1:0] send_l_ff, send_r_ff, out_l_ff, out_r_ff;

   assign dry_w = MIX_FULL - cfg.wet_mix;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         STEP_SEND_L: begin
            mul_a = WW'(dry_l);
            mul_b = (MIX_BITS+1)'(cfg.send_gain);
         end
         STEP_SEND_R: begin
            mul_a = WW'(dry_r);
            mul_b = (MIX_BITS+1)'(cfg.send_gain);
         end
         STEP_WET_L: begin
            mul_a = WW'(wet_l);
            mul_b = (MIX_BITS+1)'(cfg.return_gain);
         end
         STEP_WET_R: begin
            mul_a = WW'(wet_r);
            mul_b = (MIX_BITS+1)'(cfg.return_gain);
         end
         STEP_DRY_L: begin
            mul_a = WW'(dry_l);
            mul_b = (MIX_BITS+1)'(dry_w);
         end
         STEP_MIX_L: begin
            mul_a = wl_ff;
            mul_b = (MIX_BITS+1)'(cfg.wet_mix);
         end
         STEP_DRY_R: begin
            mul_a = WW'(dry_r);
            mul_b = (MIX_BITS+1)'(dry_w);
         end
         STEP_MIX_R: begin
            mul_a = wr_ff;
            mul_b = (MIX_BITS+1)'(cfg.wet_mix);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign prod_x    = SW'(prod_ff);
   assign gain_rnd  = (prod_x + HALF_GAIN) >>> GAIN_FRAC;
   assign blend_sum = SW'(acc_ff) + prod_x;
   assign blend_rnd = (blend_sum + HALF_MIX) >>> MIX_FRAC;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_SEND_L;
      end else if (busy_ff) begin
         if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // prod_ff holds the product issued in the previous step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (busy_ff) begin
         unique case (step_ff)
            STEP_SEND_R: send_l_ff <= sat_sample(gain_rnd);
            STEP_WET_L:  send_r_ff <= sat_sample(gain_rnd);
            STEP_WET_R:  wl_ff     <= WW'(gain_rnd);
            STEP_DRY_L:  wr_ff     <= WW'(gain_rnd);
            STEP_MIX_L:  acc_ff    <= prod_ff;
            STEP_DRY_R:  out_l_ff  <= sat_sample(blend_rnd);
            STEP_MIX_R:  acc_ff    <= prod_ff;
            STEP_LAST:   out_r_ff  <= sat_sample(blend_rnd);
            default: ;
         endcase
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (step_ff == STEP_LAST);
   assign send_l    = send_l_ff;
   assign send_r    = send_r_ff;
   assign out_l     = out_l_ff;
   assign out_r     = out_r_ff;

endmodule

// File: design/insert_send_return_latency_mixer_top.sv
// ----------------------------------------------------------------------------
// insert_send_return_latency_mixer_top: send/return mixer with delay
// Takes one stereo frame per word (dry pair and effect return pair), gives
// the send pair and the dry/wet blended output pair.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req channel: one frame per word. rsp channel: one result word per frame.
//  - csr port: write enable, index, data; write only while the block is idle.
//  - A frame is accepted only when the control is idle; req_tready drops
//    while a frame is being computed or its result waits for the output
//    register.
//  - The single shared multiplier does eight products in sequence, one
//    more step rounds the last product, then the result is loaded and
//    the control returns to idle before it takes the next frame; in
//    bypass the multiplier is skipped and the result is loaded directly.
//  - The return pair goes into two block RAMs at the write pointer; the
//    delayed pair is read in the acceptance cycle (registered read).
//  - Reset: registers go to their defaults, write pointer to zero. Delay
//    entries not yet written read as zero (tracked by a wrap flag), so no
//    clearing pass is needed and frames are accepted right after reset.
//  - Stall: the output register holds a result until rsp_tready; the next
//    frame may be accepted and computed meanwhile, then waits to be loaded.
// ----------------------------------------------------------------------------
module insert_send_return_latency_mixer_top import ismix_pkg::*; #(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // dry_left, dry_right, return_left, return_right (low to high), zero pad
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // send_left, send_right, out_left, out_right (low to high), zero pad
   output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SB      = SAMPLE_BITS;
   localparam int TDATA_W = ((4*SAMPLE_BITS+7)/8)*8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [GAIN_BITS-1:0]    send_gain_ff, return_gain_ff;
   logic [MIX_BITS-1:0]     wet_mix_ff;
   logic [LATENCY_BITS-1:0] latency_ff;
   logic                    bypass_ff, stereo_ff;

   logic signed [SB-1:0] req_dry_l, req_dry_r, req_ret_l, req_ret_r;
   logic signed [SB-1:0] dl_ff, dr_ff;
   logic signed [SB-1:0] wet_l, wet_r;
   logic signed [SB-1:0] mac_send_l, mac_send_r, mac_out_l, mac_out_r;
   logic signed [SB-1:0] res_send_l, res_send_r, res_out_l, res_out_r;
   logic                 req_accept, mac_start, load;
   gain_cfg_type         gain_cfg;
   mac_stat_type         mac_stat;
   logic [TDATA_W-1:0]   rsp_tdata_ff;
   logic                 rsp_tvalid_ff;

   assign req_dry_l = req_tdata[SB-1:0];
   assign req_dry_r = req_tdata[2*SB-1:SB];
   assign req_ret_l = req_tdata[3*SB-1:2*SB];
   assign req_ret_r = req_tdata[4*SB-1:3*SB];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         send_gain_ff   <= SEND_GAIN_RESET;
         return_gain_ff <= RETURN_GAIN_RESET;
         wet_mix_ff     <= WET_MIX_RESET;
         latency_ff     <= '0;
         bypass_ff      <= 1'b0;
         stereo_ff      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEND_GAIN:   send_gain_ff   <= csr_wdata[GAIN_BITS-1:0];
            CSR_RETURN_GAIN: return_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_WET_MIX:     wet_mix_ff     <= csr_wdata[MIX_BITS-1:0];
            CSR_LATENCY:     latency_ff     <= csr_wdata[LATENCY_BITS-1:0];
            CSR_BYPASS:      bypass_ff      <= csr_wdata[0];
            CSR_STEREO:      stereo_ff      <= csr_wdata[0];
            default: ;   // unused indexes are dropped
         endcase
      end
   end

   assign gain_cfg.send_gain   = send_gain_ff;
   assign gain_cfg.return_gain = return_gain_ff;
   assign gain_cfg.wet_mix     = (wet_mix_ff > MIX_FULL) ? MIX_FULL : wet_mix_ff;

   // ---- control ----
   always_comb begin
      state_in  = state_ff;
      mac_start = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (bypass_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in  = ST_CALC;
                  mac_start = 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (mac_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // dry pair of the frame; mono takes left for both
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dl_ff <= req_dry_l;
         dr_ff <= stereo_ff ? req_dry_r : req_dry_l;
      end
   end

   // ---- delay memories (untouched in bypass) ----
   ismix_delay #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_delay (
      .clock     (clock),
      .reset     (reset),
      .wr_strobe (req_accept && !bypass_ff),
      .rd_strobe (req_accept),
      .ret_l     (req_ret_l),
      .ret_r     (req_ret_r),
      .latency   (latency_ff),
      .wet_l     (wet_l),
      .wet_r     (wet_r)
   );

   // ---- gains and blend ----
   ismix_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .cfg    (gain_cfg),
      .dry_l  (dl_ff),
      .dry_r  (dr_ff),
      .wet_l  (wet_l),
      .wet_r  (wet_r),
      .stat   (mac_stat),
      .send_l (mac_send_l),
      .send_r (mac_send_r),
      .out_l  (mac_out_l),
      .out_r  (mac_out_r)
   );

   // ---- result word ----
   always_comb begin
      if (bypass_ff) begin
         res_send_l = '0;
         res_send_r = '0;
         res_out_l  = dl_ff;
         res_out_r  = dr_ff;
      end else begin
         res_send_l = mac_send_l;
         res_send_r = mac_send_r;
         res_out_l  = mac_out_l;
         res_out_r  = stereo_ff ? mac_out_r : mac_out_l;   // mono mirrors left
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= TDATA_W'({res_out_r, res_out_l, res_send_r, res_send_l});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---- checks ----
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> (state_ff == ST_CALC))
      else $error("multiply sequence finished outside CALC");

   a_start_mac: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !bypass_ff) |=> mac_stat.busy)
      else $error("accepted frame did not start the multiply sequence");

   a_mono_mirror: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !stereo_ff) |->
         (rsp_tdata_ff[4*SB-1:3*SB] == rsp_tdata_ff[3*SB-1:2*SB]))
      else $error("mono result with out_right different from out_left");

endmodule

// File: verif/tb_insert_send_return_latency_mixer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_insert_send_return_latency_mixer_top: self-checking bench for the mixer
// A queue-fed driver offers stereo frames with random gaps. A monitor takes
// results with random stalls and one long hold-off. Each result is checked
// field by field against a predictor that keeps its own delay lines, write
// pointer and register copies. Register settings change only between
// phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_insert_send_return_latency_mixer_top import ismix_pkg::*;;

   localparam int SB      = SAMPLE_BITS_DEF;
   localparam int DEPTH   = DELAY_DEPTH_DEF;
   localparam int TDATA_W = ((4*SB+7)/8)*8;

   localparam int CYCLE_LIMIT = 1000000;   // watchdog, several times the slowest run
   localparam int SETTLE      = 20;        // idle cycles before a register write
   localparam int HOLD_AT     = 400;       // accepted words before the long hold-off
   localparam int HOLD_LEN    = 600;       // cycles of the long hold-off
   localparam int RAND_PHASES = 8;
   localparam int PHASE_WORDS = 230;

   localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic [SB-1:0] SALT = {(SB/2){2'b10}};
   localparam logic [SB-1:0] SONE = SB'(1);
   localparam logic [SB-1:0] SNEG = '1;

   // one input word, first field in the low bits
   typedef struct packed {
      logic signed [SB-1:0] return_right;
      logic signed [SB-1:0] return_left;
      logic signed [SB-1:0] dry_right;
      logic signed [SB-1:0] dry_left;
   } mix_frame_type;

   // one result word, first field in the low bits
   typedef struct packed {
      logic signed [SB-1:0] out_right;
      logic signed [SB-1:0] out_left;
      logic signed [SB-1:0] send_right;
      logic signed [SB-1:0] send_left;
   } mix_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // dry_left, dry_right, return_left, return_right (low to high), zero pad
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // send_left, send_right, out_left, out_right (low to high), zero pad
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;

   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   insert_send_return_latency_mixer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own register copies, delay lines and write pointer
   // ---------------------------------------------------------------------
   int send_gain_r   = int'(SEND_GAIN_RESET);
   int return_gain_r = int'(RETURN_GAIN_RESET);
   int wet_mix_r     = int'(WET_MIX_RESET);
   int latency_r     = 0;
   int bypass_r      = 0;
   int stereo_r      = 1;

   logic signed [SB-1:0] echo_left  [DEPTH];
   logic signed [SB-1:0] echo_right [DEPTH];
   int                   echo_wp = 0;

   mix_frame_type  frame_queue [$];     // words waiting for the driver
   mix_result_type expected_mix [$];    // predicted results, oldest first

   int frames_queued  = 0;
   int accepted_count = 0;
   int results_seen   = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   int feed_gap = 0, feed_calm = 0;
   int sink_gap = 0, sink_calm = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // rounding right shift: floor((v + 2^(n-1)) / 2^n)
   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n-1))) >>> n;
   endfunction

   function automatic logic [SB-1:0] clip_sample(longint v);
      longint hi;
      hi = (longint'(1) <<< (SB-1)) - 1;
      if (v > hi) return SMAX;
      if (v < -hi - 1) return SMIN;
      return SB'(v);
   endfunction

   function automatic logic [SB-1:0] blend(longint dry, longint wet, int wm);
      return clip_sample(round_shift(dry * (int'(MIX_FULL) - wm) + wet * wm, MIX_FRAC));
   endfunction

   // Computes the result of one frame and, outside bypass, advances the delay lines.
   function automatic mix_result_type mix_predict(mix_frame_type f);
      mix_result_type r;
      longint         dl, dr, wl, wr;
      int             lat, wm, rp;
      dl = f.dry_left;
      dr = stereo_r ? longint'(f.dry_right) : dl;   // mono: left feeds both
      if (bypass_r) begin
         // dry straight through, sends silent, delay lines untouched
         r.send_left  = '0;
         r.send_right = '0;
         r.out_left   = SB'(dl);
         r.out_right  = SB'(dr);
         return r;
      end
      r.send_left  = clip_sample(round_shift(dl * send_gain_r, GAIN_FRAC));
      r.send_right = clip_sample(round_shift(dr * send_gain_r, GAIN_FRAC));
      // write first: zero latency reads back this very sample
      echo_left[echo_wp]  = f.return_left;
      echo_right[echo_wp] = f.return_right;
      lat = (latency_r > DEPTH-1) ? DEPTH-1 : latency_r;
      rp  = (echo_wp + DEPTH - lat) % DEPTH;
      wl  = round_shift(longint'(echo_left[rp]) * return_gain_r, GAIN_FRAC);
      wr  = round_shift(longint'(echo_right[rp]) * return_gain_r, GAIN_FRAC);
      wm  = (wet_mix_r > int'(MIX_FULL)) ? int'(MIX_FULL) : wet_mix_r;
      r.out_left  = blend(dl, wl, wm);
      r.out_right = stereo_r ? blend(dr, wr, wm) : r.out_left;
      echo_wp = (echo_wp + 1) % DEPTH;
      return r;
   endfunction

   // Mostly no gap, often a short one, seldom a long one; now and then a
   // calm stretch with no gaps at all.
   function automatic int draw_pause(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Extremes, near-zero values and full-range random values.
   function automatic logic [SB-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return SMAX;
         1: return SMIN;
         2: return SB'($signed($urandom_range(0, 32)) - 16);
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic int rand_gain();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 16384;
         2: return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic push_frame(logic [SB-1:0] dl, logic [SB-1:0] dr,
                             logic [SB-1:0] rl, logic [SB-1:0] rr);
      mix_frame_type f;
      f.dry_left     = dl;
      f.dry_right    = dr;
      f.return_left  = rl;
      f.return_right = rr;
      frame_queue.push_back(f);
      frames_queued++;
   endtask

   // Register write; only called while the block is idle, so the predictor
   // copy can change at once.
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      case (idx)
         CSR_SEND_GAIN:   send_gain_r   = value & ((1 << GAIN_BITS) - 1);
         CSR_RETURN_GAIN: return_gain_r = value & ((1 << GAIN_BITS) - 1);
         CSR_WET_MIX:     wet_mix_r     = value & ((1 << MIX_BITS) - 1);
         CSR_LATENCY:     latency_r     = value & ((1 << LATENCY_BITS) - 1);
         CSR_BYPASS:      bypass_r      = value & 1;
         CSR_STEREO:      stereo_r      = value & 1;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Every queued word has come back, then a few quiet cycles.
   task automatic wait_idle();
      while (results_seen != frames_queued) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_settings();
      int lat_pick;
      write_reg(CSR_SEND_GAIN, rand_gain());
      write_reg(CSR_RETURN_GAIN, rand_gain());
      case ($urandom_range(0, 4))
         0: write_reg(CSR_WET_MIX, 0);
         1: write_reg(CSR_WET_MIX, int'(MIX_FULL));
         2: write_reg(CSR_WET_MIX, $urandom_range(65537, 131071));   // clamps
         default: write_reg(CSR_WET_MIX, $urandom_range(0, 65536));
      endcase
      lat_pick = $urandom_range(0, 5);
      case (lat_pick)
         0: write_reg(CSR_LATENCY, 0);
         1: write_reg(CSR_LATENCY, 4095);
         2: write_reg(CSR_LATENCY, $urandom_range(0, 4095));
         default: write_reg(CSR_LATENCY, $urandom_range(1, 40));   // short, hits fresh data
      endcase
      write_reg(CSR_BYPASS, ($urandom_range(0, 9) == 0) ? 1 : 0);
      write_reg(CSR_STEREO, $urandom_range(0, 1));
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued words on req; after each word a random gap.
   // tvalid holds until the word is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : feed
      mix_frame_type frame_on_bus;
      logic          waiting;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         waiting = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            expected_mix.push_back(mix_predict(frame_on_bus));
            accepted_count <= accepted_count + 1;
         end
         if (waiting) begin
            // word still on offer, leave the bus alone
         end else if (feed_gap > 0 || frame_queue.size() == 0) begin
            if (feed_gap > 0) feed_gap--;
            req_tvalid <= 1'b0;
         end else begin
            frame_on_bus = frame_queue.pop_front();
            req_tdata   <= TDATA_W'(frame_on_bus);
            req_tvalid  <= 1'b1;
            feed_gap     = draw_pause(feed_calm);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long hold-off on rsp, once: the sender keeps offering, so the block
   // fills its output register and the frame behind it and drops tready.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
         end
      end
   end

   task automatic check_field(string name, logic [SB-1:0] want, logic [SB-1:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("result %0d %s: expected %06h, got %06h",
                     results_seen, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: takes result words with random stalls, checks each against
   // the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sink
      mix_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = mix_result_type'(rsp_tdata[4*SB-1:0]);
            results_seen <= results_seen + 1;
            if (expected_mix.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("result word %h with no frame behind it", got);
            end else begin
               want = expected_mix.pop_front();
               check_field("send_left",  want.send_left,  got.send_left);
               check_field("send_right", want.send_right, got.send_right);
               check_field("out_left",   want.out_left,   got.out_left);
               check_field("out_right",  want.out_right,  got.out_right);
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            sink_gap    = draw_pause(sink_calm);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed phases, then random phases with fresh settings.
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         echo_left[i]  = '0;
         echo_right[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings; zero latency reads back the sample just written
      push_frame('0, '0, '0, '0);
      push_frame(SMAX, SMAX, SMAX, SMAX);
      push_frame(SMIN, SMIN, SMIN, SMIN);
      push_frame(SMAX, SMIN, SMIN, SMAX);
      push_frame(SONE, SNEG, SALT, ~SALT);
      wait_idle();

      // top gains and an over-range wet mix: saturation and mix clamp
      write_reg(CSR_SEND_GAIN, 65535);
      write_reg(CSR_RETURN_GAIN, 65535);
      write_reg(CSR_WET_MIX, 131071);
      write_reg(CSR_LATENCY, 2);
      push_frame(SMAX, SMAX, SMAX, SMAX);
      push_frame(SMIN, SMIN, SMIN, SMIN);
      push_frame(SMAX, SMIN, SMAX, SMIN);
      push_frame(~SALT, SALT, SNEG, SONE);
      wait_idle();

      // zero send, fully dry, longest delay, mono
      write_reg(CSR_SEND_GAIN, 0);
      write_reg(CSR_WET_MIX, 0);
      write_reg(CSR_LATENCY, 4095);
      write_reg(CSR_STEREO, 0);
      push_frame(SMAX, SMIN, SMIN, SMAX);
      push_frame(SMIN, SMAX, SMAX, SMIN);
      push_frame(SALT, ~SALT, SONE, SNEG);
      wait_idle();

      // bypass, mono then stereo
      write_reg(CSR_BYPASS, 1);
      push_frame(SMAX, SMIN, SONE, SNEG);
      wait_idle();
      write_reg(CSR_STEREO, 1);
      push_frame(SMIN, SMAX, SALT, SALT);
      push_frame(SALT, ~SALT, SMAX, SMIN);
      wait_idle();

      // back from bypass, fully wet: delay must not have moved
      write_reg(CSR_BYPASS, 0);
      write_reg(CSR_SEND_GAIN, 16384);
      write_reg(CSR_RETURN_GAIN, 16384);
      write_reg(CSR_WET_MIX, int'(MIX_FULL));
      write_reg(CSR_LATENCY, 1);
      push_frame(SONE, SNEG, SMAX, SMIN);
      push_frame(SNEG, SONE, SMIN, SMAX);
      push_frame('0, '0, SALT, ~SALT);
      wait_idle();

      // random phases
      for (int p = 0; p < RAND_PHASES; p++) begin
         random_settings();
         for (int n = 0; n < PHASE_WORDS; n++)
            push_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_mix.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
